// ----- rtl/etrb_pkg.sv -----
`default_nettype none
package etrb_pkg;

  typedef enum logic [2:0] {
    MODE_RECORD   = 3'd0,
    MODE_BEGIN    = 3'd1,
    MODE_SNAPSHOT = 3'd2,
    MODE_READ     = 3'd3,
    MODE_RELEASE  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_ALREADY_ON  = 3'd2,
    ST_NOT_TRACING = 3'd3,
    ST_DROPPED     = 3'd4,
    ST_NOT_FROZEN  = 3'd5,
    ST_BAD_OFFSET  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_READ  = 2'd2
  } fsm_t;

  localparam int unsigned LEN_CFG_W   = 13;
  localparam int unsigned OFFSET_W    = 12;
  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 13'd4096;

  // one ring slot as stored in the RAM
  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] id;
    logic        start;
    logic [2:0]  kind;
    logic [31:0] pid;
    logic [31:0] extra;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic clear_run;
    logic read_done;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_read;
    logic req_release;
    logic clear_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/etrb_ram.sv -----
`default_nettype none
module etrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/etrb_ctrl.sv -----
`default_nettype none
module etrb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire etrb_pkg::dp_status_t dp_st,
  output logic                     busy,
  output etrb_pkg::ctrl_cmd_t      cmd
);

  etrb_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= etrb_pkg::FSM_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    busy          = 1'b1;
    cmd.accept    = 1'b0;
    cmd.clear_run = 1'b0;
    cmd.read_done = 1'b0;
    case (state_r)
      etrb_pkg::FSM_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start && dp_st.req_read) begin
          state_nxt = etrb_pkg::FSM_READ;
        end else if (start && dp_st.req_release) begin
          state_nxt = etrb_pkg::FSM_CLEAR;
        end
      end
      etrb_pkg::FSM_READ: begin
        cmd.read_done = 1'b1;
        state_nxt     = etrb_pkg::FSM_IDLE;
      end
      etrb_pkg::FSM_CLEAR: begin
        cmd.clear_run = 1'b1;
        if (dp_st.clear_last) begin
          state_nxt = etrb_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = etrb_pkg::FSM_CLEAR;
      end
    endcase
  end

  // a read always leaves the RAM wait state for idle on the next clock
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == etrb_pkg::FSM_READ |=> state_r == etrb_pkg::FSM_IDLE)
    else $error("read wait overran");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_run |-> !cmd.accept && busy)
    else $error("request taken during clear pass");

endmodule
`default_nettype wire

// ----- rtl/etrb_dp.sv -----
`default_nettype none
module etrb_dp #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire etrb_pkg::ctrl_cmd_t               cmd,
  output etrb_pkg::dp_status_t                   dp_st,
  input  wire logic                              cfg_we,
  input  wire logic [etrb_pkg::LEN_CFG_W-1:0]    cfg_wdata,
  input  wire logic [2:0]                        in_mode,
  input  wire logic [63:0]                       in_stamp_in,
  input  wire logic [31:0]                       in_event_id,
  input  wire logic [2:0]                        in_event_kind,
  input  wire logic                              in_event_start,
  input  wire logic [31:0]                       in_task_pid,
  input  wire logic [31:0]                       in_extra_info,
  input  wire logic [etrb_pkg::OFFSET_W-1:0]     in_read_offset,
  output logic                                   out_valid,
  output logic [2:0]                             out_status,
  output logic [63:0]                            out_entry_stamp,
  output logic [31:0]                            out_entry_id,
  output logic [2:0]                             out_entry_kind,
  output logic                                   out_entry_start,
  output logic [31:0]                            out_entry_pid,
  output logic [31:0]                            out_entry_extra
);

  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
  localparam int unsigned LW     = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW     = (LW > etrb_pkg::LEN_CFG_W) ? LW : etrb_pkg::LEN_CFG_W;
  localparam int unsigned ENTRY_WL = etrb_pkg::ENTRY_W;

  logic [etrb_pkg::LEN_CFG_W-1:0] buffer_len_r;
  logic                           tracing_on_r, tracing_on_nxt;
  logic                           frozen_r, frozen_nxt;
  logic [ADDR_W-1:0]              write_slot_r, write_slot_nxt;
  logic [ADDR_W-1:0]              clr_addr_r;
  etrb_pkg::status_t              rd_status_r, rd_status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  etrb_pkg::status_t              out_status_r, out_status_nxt;
  etrb_pkg::entry_t               out_entry_r, out_entry_nxt;

  etrb_pkg::mode_t                mode;
  etrb_pkg::status_t              req_status;
  etrb_pkg::entry_t               wr_entry, rd_entry;
  logic [ENTRY_WL-1:0]            rdata;
  logic [CW-1:0]                  len_ext, eff_len, slot_inc;
  logic [ADDR_W-1:0]              slot;
  logic [CW:0]                    idx_sum;
  logic [ADDR_W-1:0]              rd_idx;
  logic                           rec_we, ram_we;
  logic [ADDR_W-1:0]              ram_waddr;
  logic [ENTRY_WL-1:0]            ram_wdata;

  assign mode = etrb_pkg::mode_t'(in_mode);

  // effective length: 0 acts as 1, above the ring size clamps to it
  always_comb begin
    len_ext = CW'(buffer_len_r);
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > CW'(RING_DEPTH)) begin
      eff_len = CW'(RING_DEPTH);
    end else begin
      eff_len = len_ext;
    end
    slot     = (CW'(write_slot_r) < eff_len) ? write_slot_r : '0;
    slot_inc = CW'(slot) + CW'(1);
    idx_sum  = (CW + 1)'(slot) + (CW + 1)'(in_read_offset);
    if (idx_sum >= {1'b0, eff_len}) begin
      idx_sum = idx_sum - {1'b0, eff_len};
    end
    rd_idx = idx_sum[ADDR_W-1:0];
  end

  always_comb begin
    dp_st.req_read    = (mode == etrb_pkg::MODE_READ);
    dp_st.req_release = (mode == etrb_pkg::MODE_RELEASE);
    dp_st.clear_last  = (clr_addr_r == ADDR_W'(RING_DEPTH - 1));
  end

  always_comb begin
    tracing_on_nxt = tracing_on_r;
    frozen_nxt     = frozen_r;
    write_slot_nxt = write_slot_r;
    rd_status_nxt  = rd_status_r;
    req_status     = etrb_pkg::ST_OK;
    rec_we         = 1'b0;
    if (cmd.accept) begin
      case (mode)
        etrb_pkg::MODE_RECORD: begin
          if (tracing_on_r && !frozen_r) begin
            rec_we         = 1'b1;
            write_slot_nxt = (slot_inc >= eff_len) ? '0 : slot_inc[ADDR_W-1:0];
          end else begin
            req_status = etrb_pkg::ST_DROPPED;
          end
        end
        etrb_pkg::MODE_BEGIN: begin
          if (frozen_r) begin
            req_status = etrb_pkg::ST_NOT_READY;
          end else if (tracing_on_r) begin
            req_status = etrb_pkg::ST_ALREADY_ON;
          end else begin
            tracing_on_nxt = 1'b1;
          end
        end
        etrb_pkg::MODE_SNAPSHOT: begin
          if (!tracing_on_r) begin
            req_status = etrb_pkg::ST_NOT_TRACING;
          end else if (frozen_r) begin
            req_status = etrb_pkg::ST_NOT_READY;
          end else begin
            tracing_on_nxt = 1'b0;
            frozen_nxt     = 1'b1;
          end
        end
        etrb_pkg::MODE_READ: begin
          if (!frozen_r) begin
            rd_status_nxt = etrb_pkg::ST_NOT_FROZEN;
          end else if (CW'(in_read_offset) >= eff_len) begin
            rd_status_nxt = etrb_pkg::ST_BAD_OFFSET;
          end else begin
            rd_status_nxt = etrb_pkg::ST_OK;
          end
        end
        etrb_pkg::MODE_RELEASE: begin
          write_slot_nxt = '0;
          frozen_nxt     = 1'b0;
        end
        default: begin
          req_status = etrb_pkg::ST_DROPPED;
        end
      endcase
    end
  end

  always_comb begin
    wr_entry.stamp = in_stamp_in;
    wr_entry.id    = in_event_id;
    wr_entry.start = in_event_start;
    wr_entry.kind  = in_event_kind;
    wr_entry.pid   = in_task_pid;
    wr_entry.extra = in_extra_info;
    ram_we    = cmd.clear_run || rec_we;
    ram_waddr = cmd.clear_run ? clr_addr_r : slot;
    ram_wdata = cmd.clear_run ? '0 : wr_entry;
  end

  etrb_ram #(
    .WIDTH (ENTRY_WL),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (rd_idx),
    .rdata_r (rdata)
  );

  assign rd_entry = etrb_pkg::entry_t'(rdata);

  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    if (cmd.read_done) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = rd_status_r;
      out_entry_nxt  = (rd_status_r == etrb_pkg::ST_OK) ? rd_entry : '0;
    end else if (cmd.accept && !dp_st.req_read) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = req_status;
      out_entry_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_len_r <= etrb_pkg::LEN_RESET;
      tracing_on_r <= 1'b0;
      frozen_r     <= 1'b0;
      write_slot_r <= '0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_len_r <= cfg_wdata;
      end
      tracing_on_r <= tracing_on_nxt;
      frozen_r     <= frozen_nxt;
      write_slot_r <= write_slot_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cmd.clear_run) begin
        clr_addr_r <= dp_st.clear_last ? '0 : clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_status_r  <= rd_status_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_stamp = out_entry_r.stamp;
  assign out_entry_id    = out_entry_r.id;
  assign out_entry_kind  = out_entry_r.kind;
  assign out_entry_start = out_entry_r.start;
  assign out_entry_pid   = out_entry_r.pid;
  assign out_entry_extra = out_entry_r.extra;

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(tracing_on_r && frozen_r))
    else $error("tracing and frozen both set");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(write_slot_r) < CW'(RING_DEPTH))
    else $error("write slot beyond ring");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && !dp_st.req_read |=> out_valid_r)
    else $error("result missing after request");

  a_clear_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_run |-> !rec_we)
    else $error("record write during clear pass");

endmodule
`default_nettype wire

// ----- rtl/event_trace_ring_buffer_core.sv -----
`default_nettype none
// Latency: record, begin, snapshot and release answer in the cycle after the request is taken;
// read answers through the registered RAM read, then the output register.
// Throughput: one record/begin/snapshot request per cycle while busy is low; a read holds busy in its RAM wait.
// Release then holds busy while the RAM is swept to zero, one entry a cycle.
// Reset (rst_n low, synchronous) runs the same clearing pass; buffer_len = 4096.
// Results appear on out_valid for one cycle; the receiver cannot stall them.
module event_trace_ring_buffer_core #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: ring length in use
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [63:0] in_stamp_in,
  input  wire logic [31:0] in_event_id,
  input  wire logic [2:0]  in_event_kind,
  input  wire logic        in_event_start,
  input  wire logic [31:0] in_task_pid,
  input  wire logic [31:0] in_extra_info,
  input  wire logic [11:0] in_read_offset,
  // result channel
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [63:0]      out_entry_stamp,
  output logic [31:0]      out_entry_id,
  output logic [2:0]       out_entry_kind,
  output logic             out_entry_start,
  output logic [31:0]      out_entry_pid,
  output logic [31:0]      out_entry_extra
);

  // Controller sequences idle / read wait / clearing pass; the datapath owns
  // the run flags, write slot, length register and the trace RAM.
  etrb_pkg::ctrl_cmd_t  cmd;
  etrb_pkg::dp_status_t dp_st;

  etrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .dp_st (dp_st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Records are written straight into the RAM on the edge that takes the
  // request, so back-to-back records need no extra state.
  etrb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_st           (dp_st),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_mode),
    .in_stamp_in     (in_stamp_in),
    .in_event_id     (in_event_id),
    .in_event_kind   (in_event_kind),
    .in_event_start  (in_event_start),
    .in_task_pid     (in_task_pid),
    .in_extra_info   (in_extra_info),
    .in_read_offset  (in_read_offset),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_stamp (out_entry_stamp),
    .out_entry_id    (out_entry_id),
    .out_entry_kind  (out_entry_kind),
    .out_entry_start (out_entry_start),
    .out_entry_pid   (out_entry_pid),
    .out_entry_extra (out_entry_extra)
  );

  // one result per taken read: out_valid stays low in the RAM wait, then the read result follows
  a_read_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == etrb_pkg::MODE_READ |=> !out_valid ##1 out_valid)
    else $error("read result timing wrong");

  a_busy_after_release: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == etrb_pkg::MODE_RELEASE |=> busy && out_valid)
    else $error("release did not start clearing");

  a_idle_valid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(start && !busy) |-> $past(busy, 1) && !$past(busy, 2) == 1'b0 ||
      $past(start && !busy, 2))
    else $error("unrequested result");

endmodule
`default_nettype wire
